// ----- design/ple_pkg.sv -----
// ple_pkg: shared types and constants for the point list engine.
// No dependencies; used by every module of the block.
`default_nettype none
package ple_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned TDATA_W   = 48;

  typedef enum logic [1:0] {
    CMD_FRONT  = 2'd0,
    CMD_BACK   = 2'd1,
    CMD_AT     = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // list operation selected for one command
  typedef struct packed {
    logic               ins;
    logic               rem;
    logic [POS_W-1:0]   slot;
    status_t            status;
  } op_t;

endpackage
`default_nettype wire

// ----- design/ple_decode.sv -----
// ple_decode: checks a command against the current entry count and picks
// the list operation and status. Depends on ple_pkg.
`default_nettype none
module ple_decode
  import ple_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  cmd_t             command,
  input  logic [POS_W-1:0] position,
  input  logic [CNT_W-1:0] count,
  output op_t              op
);

  logic             empty;
  logic             full;
  logic [POS_W:0]   limit;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign limit = (POS_W + 1)'(count) + (POS_W + 1)'(1);

  always_comb begin
    op        = '0;
    op.status = ST_OK;
    unique case (command)
      CMD_REMOVE: begin
        if (empty) op.status = ST_EMPTY;
        else       op.rem    = 1'b1;
      end
      CMD_FRONT: begin
        if (full) op.status = ST_FULL;
        else      op.ins    = 1'b1;
      end
      CMD_BACK: begin
        if (full) begin
          op.status = ST_FULL;
        end else if (empty) begin
          op.status = ST_EMPTY;
        end else begin
          op.ins  = 1'b1;
          op.slot = POS_W'(count);
        end
      end
      CMD_AT: begin
        if (full) begin
          op.status = ST_FULL;
        end else if (position == '0 || {1'b0, position} > limit) begin
          op.status = ST_BADPOS;
        end else begin
          op.ins  = 1'b1;
          op.slot = position - POS_W'(1);
        end
      end
      default: op.status = ST_OK;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/ple_list.sv -----
// ple_list: row of point cells; every cell loads from itself, its neighbor
// or the new point in parallel, so one insert or remove finishes per cycle
// while fire is high. Depends on ple_pkg.
`default_nettype none
module ple_list
  import ple_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  op_t                op,
  input  logic [COORD_W-1:0] x_in,
  input  logic [COORD_W-1:0] y_in,
  output logic [CNT_W-1:0]   count,
  output logic [CNT_W-1:0]   count_next,
  output logic [COORD_W-1:0] x_front,
  output logic [COORD_W-1:0] y_front
);

  logic [COORD_W-1:0] px [DEPTH];
  logic [COORD_W-1:0] py [DEPTH];
  logic [COORD_W-1:0] px_next [DEPTH];
  logic [COORD_W-1:0] py_next [DEPTH];

  assign x_front = px[0];
  assign y_front = py[0];

  always_comb begin
    count_next = count;
    if (op.ins)      count_next = count + CNT_W'(1);
    else if (op.rem) count_next = count - CNT_W'(1);
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    always_comb begin
      px_next[k] = px[k];
      py_next[k] = py[k];
      if (op.ins) begin
        if (op.slot == POS_W'(k)) begin
          px_next[k] = x_in;
          py_next[k] = y_in;
        end else if (op.slot < POS_W'(k)) begin
          // open the gap: take the entry below
          px_next[k] = px[(k > 0) ? k - 1 : 0];
          py_next[k] = py[(k > 0) ? k - 1 : 0];
        end
      end else if (op.rem && k < DEPTH - 1) begin
        px_next[k] = px[(k < DEPTH - 1) ? k + 1 : k];
        py_next[k] = py[(k < DEPTH - 1) ? k + 1 : k];
      end
    end

    always_ff @(posedge clk) begin
      if (fire) begin
        px[k] <= px_next[k];
        py[k] <= py_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/point_list_engine.sv -----
// point_list_engine: ordered list of signed points with insert/append/
// insert-at/remove-front commands. Depends on ple_pkg, ple_decode, ple_list.
//
//  channel | beat fields (tdata, low bit first)              | tuser/tlast
//  s_*     | command[1:0] x_in[17:2] y_in[33:18] position[40:34] | none
//  m_*     | x_out[15:0] y_out[31:16] status[33:32] entry_count[40:34] | none
//
// A beat is latched in an input register, then the list update writes the
// result register: one command per cycle while the result is not stalled.
// The list shift is done by all cells in parallel, so DEPTH does not change
// the rate. Reset empties the list and drops both registers' valid flags.
// A stalled result holds the input register; a new beat is taken whenever
// the input register is empty or moves on in the same cycle.
`default_nettype none
module point_list_engine
  import ple_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // command, x_in, y_in, position
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata    // x_out, y_out, status, entry_count
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic               in_valid;
  cmd_t               in_cmd;
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic [POS_W-1:0]   in_pos;

  logic               fire;
  op_t                op;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [COORD_W-1:0] x_front;
  logic [COORD_W-1:0] y_front;

  logic [COORD_W-1:0] x_out;
  logic [COORD_W-1:0] y_out;
  status_t            status;
  logic [COUNT_W-1:0] entry_count;

  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd <= cmd_t'(s_tdata[1:0]);
      in_x   <= s_tdata[17:2];
      in_y   <= s_tdata[33:18];
      in_pos <= s_tdata[40:34];
    end
  end

  ple_decode #(.DEPTH(DEPTH), .CNT_W(CNT_W)) u_decode (
    .command  (in_cmd),
    .position (in_pos),
    .count    (count),
    .op       (op)
  );

  ple_list #(.DEPTH(DEPTH), .CNT_W(CNT_W)) u_list (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .op         (op),
    .x_in       (in_x),
    .y_in       (in_y),
    .count      (count),
    .count_next (count_next),
    .x_front    (x_front),
    .y_front    (y_front)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      x_out       <= op.rem ? x_front : '0;
      y_out       <= op.rem ? y_front : '0;
      status      <= op.status;
      entry_count <= COUNT_W'(count_next);
    end
  end

  assign m_tdata = {7'd0, entry_count, status, y_out, x_out};

endmodule
`default_nettype wire
